[rtl/bte_pkg.sv]
package bte_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic [1:0] CFG_T_MAX      = 2'd0;
  localparam logic [1:0] CFG_NUM_POINTS = 2'd1;
  localparam logic [1:0] CFG_DIMS       = 2'd2;
  localparam logic [1:0] CFG_UNUSED     = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  point_index;
    logic [2:0]  coord_index;
    logic [31:0] coord_value;
    logic [31:0] sample_time;
  } req_t;

endpackage

[rtl/bte_divider.sv]
module bte_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quo_q[63]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/bte_front.sv]
module bte_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bte_pkg::req_t      in_req_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output bte_pkg::req_t      q_req_o
);

  bte_pkg::req_t mem_q [2];
  logic [1:0] wp_q, rp_q;
  logic full, empty, push;

  assign empty      = (wp_q == rp_q);
  assign full       = (wp_q[0] == rp_q[0]) && (wp_q[1] != rp_q[1]);
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = !empty;
  assign q_req_o    = mem_q[rp_q[0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 2'd1;
      end
      if (q_pop_i && !empty) begin
        rp_q <= rp_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q[0]] <= in_req_i;
    end
  end

endmodule

[rtl/bte_back.sv]
module bte_back #(
  parameter int unsigned MAX_POINTS = 8,
  parameter int unsigned MAX_DIMS   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  bte_pkg::req_t q_req_i,
  input  logic [31:0]   t_max_i,
  input  logic [3:0]    num_points_i,
  input  logic [3:0]    dims_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    out_coord_o,
  output logic [31:0]   position_o,
  output logic [31:0]   velocity_o,
  output logic [31:0]   acceleration_o,
  output logic          last_o
);

  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned AW = PW + DW;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned DimCap = (MAX_DIMS < 8) ? MAX_DIMS : 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UDIV  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_LERP  = 4'd3;
  localparam logic [3:0] S_LMUL  = 4'd4;
  localparam logic [3:0] S_VDIV  = 4'd5;
  localparam logic [3:0] S_ADIV1 = 4'd6;
  localparam logic [3:0] S_ADIV2 = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_LREAD = 4'd9;

  logic [31:0] cpmem [2**AW];
  logic [31:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  logic [3:0]  st_q, st_d;
  logic [31:0] tm_q;
  logic [30:0] u_q;
  logic        past_q;
  logic [NW-1:0] np_q, n_q;
  logic [3:0]  nd_q;
  logic [2:0]  d_q;
  logic [NW-1:0] k_q, cnt_q;
  logic signed [33:0] buf_q [MAX_POINTS];
  logic signed [33:0] dif1_q;
  logic signed [35:0] dif2_q;
  logic [63:0] prod_q;
  logic        pneg_q;
  logic        vneg_q, aneg_q;
  logic [31:0] vel_q, acc_q, pos_q;
  logic        ov_q;
  logic [2:0]  oc_q;
  logic        ol_q;

  logic        dv_start;
  logic [63:0] dv_num;
  logic        dv_done;
  logic [63:0] dv_quo;

  bte_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (tm_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  function automatic logic [31:0] sat(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (!neg) begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
    return r;
  endfunction

  logic [31:0] tsc;
  logic [31:0] tmx;
  logic        wr_ok;
  logic signed [33:0] lp, lq, ld;
  logic [33:0] lmag;
  logic [34:0] lr;
  logic signed [35:0] d2;
  logic [35:0] amag;
  logic [33:0] vmag;
  logic [NW-1:0] npc;
  logic [3:0]  ndc;
  logic        accept;

  assign tmx = (t_max_i == 32'd0) ? 32'd1 : t_max_i;
  assign tsc = (q_req_i.sample_time > tmx) ? tmx : q_req_i.sample_time;
  assign wr_ok = ({29'd0, q_req_i.point_index} < MAX_POINTS)
              && ({29'd0, q_req_i.coord_index} < MAX_DIMS);
  assign npc = (num_points_i < 4'd3) ? NW'(3)
             : ({28'd0, num_points_i} > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points_i);
  assign ndc = (dims_i == 4'd0) ? 4'd1
             : ({28'd0, dims_i} > DimCap) ? 4'(DimCap) : dims_i;

  assign accept  = (st_q == S_IDLE) && q_valid_i;
  assign q_pop_o = accept;
  assign rd_addr = {k_q[PW-1:0], DW'(d_q)};
  assign wr_addr = {PW'(q_req_i.point_index), DW'(q_req_i.coord_index)};

  assign lp   = buf_q[k_q[PW-1:0]];
  assign lq   = buf_q[PW'(k_q + NW'(1))];
  assign ld   = lq - lp;
  assign lmag = ld[33] ? 34'(-ld) : 34'(ld);
  assign lr   = 35'((prod_q + 64'd536870912) >> 30);
  assign d2   = 36'(buf_q[2]) - (36'(buf_q[1]) <<< 1) + 36'(buf_q[0]);
  assign amag = dif2_q[35] ? 36'(-dif2_q) : 36'(dif2_q);
  assign vmag = dif1_q[33] ? 34'(-dif1_q) : 34'(dif1_q);

  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    unique case (st_q)
      S_IDLE: begin
        dv_start = accept && (q_req_i.req_type == bte_pkg::REQ_EVAL);
        dv_num   = ({32'd0, tsc} << 30) + {33'd0, tmx[31:1]};
      end
      S_VDIV: begin
        dv_start = (cnt_q == NW'(0));
        dv_num   = (prod_q << 16) + {33'd0, tm_q[31:1]};
      end
      S_ADIV1: begin
        dv_start = (cnt_q == NW'(0));
        dv_num   = (prod_q << 16) + {33'd0, tm_q[31:1]};
      end
      S_ADIV2: begin
        dv_start = (cnt_q == NW'(0));
        dv_num   = (((dv_quo > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : dv_quo) << 16)
                 + {33'd0, tm_q[31:1]};
      end
      default: begin
        dv_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && q_req_i.req_type == bte_pkg::REQ_WRITE && wr_ok) begin
      cpmem[wr_addr] <= q_req_i.coord_value;
    end
    rd_q <= cpmem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_OUT && !ov_q) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (accept && q_req_i.req_type == bte_pkg::REQ_EVAL) st_d = S_UDIV;
      S_UDIV:  if (dv_done) st_d = S_LREAD;
      S_LREAD: st_d = S_LOAD;
      S_LOAD:  if (k_q == np_q) st_d = S_LERP;
      S_LERP:  st_d = S_LMUL;
      S_LMUL:  st_d = (k_q + NW'(2) >= cnt_q) ?
                       ((cnt_q == NW'(2)) ? S_VDIV : S_LERP) : S_LERP;
      S_VDIV:  if (dv_done) st_d = S_ADIV1;
      S_ADIV1: if (dv_done) st_d = S_ADIV2;
      S_ADIV2: if (dv_done) st_d = S_OUT;
      S_OUT:   if (!ov_q) st_d = (d_q == 3'(nd_q - 4'd1)) ? S_IDLE : S_LREAD;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        tm_q   <= tmx;
        past_q <= (q_req_i.sample_time > tmx);
        np_q   <= npc;
        n_q    <= npc - NW'(1);
        nd_q   <= ndc;
        d_q    <= '0;
        k_q    <= '0;
      end
      S_UDIV: begin
        if (dv_done) u_q <= dv_quo[30:0];
        k_q <= '0;
      end
      S_LREAD: begin
        k_q <= NW'(1);
      end
      S_LOAD: begin
        buf_q[PW'(k_q - NW'(1))] <= {{2{rd_q[31]}}, rd_q};
        if (k_q == np_q) begin
          k_q   <= '0;
          cnt_q <= np_q;
        end else begin
          k_q <= k_q + NW'(1);
        end
      end
      S_LERP: begin
        if (k_q == '0 && cnt_q == NW'(3)) dif2_q <= d2;
        if (k_q == '0 && cnt_q == NW'(2)) dif1_q <= buf_q[1] - buf_q[0];
        prod_q <= {30'd0, lmag} * {33'd0, u_q};
        pneg_q <= ld[33];
      end
      S_LMUL: begin
        buf_q[k_q[PW-1:0]] <= pneg_q ? lp - 34'(lr) : lp + 34'(lr);
        if (k_q + NW'(2) >= cnt_q) begin
          k_q <= '0;
          if (cnt_q == NW'(2)) begin
            prod_q <= 64'({30'd0, vmag} * {{(64-NW){1'b0}}, n_q});
            vneg_q <= dif1_q[33];
            cnt_q  <= '0;
          end else begin
            cnt_q <= cnt_q - NW'(1);
          end
        end else begin
          k_q <= k_q + NW'(1);
        end
      end
      S_VDIV: begin
        if (dv_done) begin
          vel_q  <= sat(vneg_q, dv_quo);
          prod_q <= 64'({28'd0, amag} * {{(64-NW){1'b0}}, n_q}
                        * {{(64-NW){1'b0}}, NW'(n_q - NW'(1))});
          aneg_q <= dif2_q[35];
          cnt_q  <= '0;
        end else begin
          cnt_q <= NW'(1);
        end
      end
      S_ADIV1: begin
        if (dv_done) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= NW'(1);
        end
      end
      S_ADIV2: begin
        if (dv_done) begin
          acc_q <= past_q ? 32'd0 : sat(aneg_q, dv_quo);
          pos_q <= buf_q[0][31:0];
          cnt_q <= '0;
        end else begin
          cnt_q <= NW'(1);
        end
      end
      S_OUT: begin
        if (!ov_q) begin
          oc_q <= d_q;
          ol_q <= (d_q == 3'(nd_q - 4'd1));
          d_q  <= d_q + 3'd1;
          k_q  <= '0;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  logic [31:0] opos_q, ovel_q, oacc_q;
  always_ff @(posedge clk_i) begin
    if (st_q == S_OUT && !ov_q) begin
      opos_q <= pos_q;
      ovel_q <= vel_q;
      oacc_q <= acc_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_coord_o    = oc_q;
  assign position_o     = opos_q;
  assign velocity_o     = ovel_q;
  assign acceleration_o = oacc_q;
  assign last_o         = ol_q;

endmodule

[rtl/bezier_trajectory_evaluator_core.sv]
// Write transaction: stored in control point storage when accepted; one per cycle while the back end is idle.
// Evaluate transaction: one time divide, then per coordinate the points are loaded and the
// de Casteljau steps run, three divides follow on the shared radix-2 divider (velocity and
// two acceleration scalings) and the result is handed off.
// Sequential: the next evaluate starts after the last result registers; a stalled result holds.
// Reset clears control and loads the configuration defaults; control point storage stays undefined.
module bezier_trajectory_evaluator_core #(
  parameter int unsigned MAX_POINTS = 8,
  parameter int unsigned MAX_DIMS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [2:0]  point_index_i,
  input  logic [2:0]  coord_index_i,
  input  logic [31:0] coord_value_i,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_coord_o,
  output logic [31:0] position_o,
  output logic [31:0] velocity_o,
  output logic [31:0] acceleration_o,
  output logic        last_o
);

  logic [31:0] t_max_q;
  logic [3:0]  np_q, nd_q;
  bte_pkg::req_t in_req, q_req;
  logic q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_max_q <= 32'd65536;
      np_q    <= 4'd4;
      nd_q    <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bte_pkg::CFG_T_MAX:      t_max_q <= cfg_data_i;
        bte_pkg::CFG_NUM_POINTS: np_q    <= cfg_data_i[3:0];
        bte_pkg::CFG_DIMS:       nd_q    <= cfg_data_i[3:0];
        default:                 t_max_q <= t_max_q;
      endcase
    end
  end

  assign in_req = '{req_type: req_type_i, point_index: point_index_i,
                    coord_index: coord_index_i, coord_value: coord_value_i,
                    sample_time: sample_time_i};

  bte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  bte_back #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_req_i        (q_req),
    .t_max_i        (t_max_q),
    .num_points_i   (np_q),
    .dims_i         (nd_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_coord_o    (out_coord_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .last_o         (last_o)
  );

endmodule

[rtl/bte_checker.sv]
module bte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  out_coord_o,
  input logic        last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_coord_o))
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> !out_valid_o)
    else $error("results too close");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_coord_o == 3'd7 |-> last_o)
    else $error("coordinate 7 not last");

endmodule

bind bezier_trajectory_evaluator_core bte_checker u_chk (.*);

[dv/tb_bezier_trajectory_evaluator_core.sv]
`timescale 1ns / 100ps

module tb_bezier_trajectory_evaluator_core;

  localparam int unsigned MaxPoints = 8;
  localparam int unsigned MaxDims   = 8;

  typedef struct {
    logic [2:0]  coord;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic        last;
  } sample_t;

  typedef struct {
    logic        req;
    logic [2:0]  pi;
    logic [2:0]  ci;
    logic [31:0] val;
    logic [31:0] t;
    logic        chk;
    logic [31:0] epos;
    logic [31:0] evel;
    logic [31:0] eacc;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [2:0]  point_index_i;
  logic [2:0]  coord_index_i;
  logic [31:0] coord_value_i;
  logic [31:0] sample_time_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  out_coord_o;
  logic [31:0] position_o;
  logic [31:0] velocity_o;
  logic [31:0] acceleration_o;
  logic        last_o;

  bezier_trajectory_evaluator_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .point_index_i, .coord_index_i,
    .coord_value_i, .sample_time_i, .out_valid_o, .out_stall_i, .out_coord_o,
    .position_o, .velocity_o, .acceleration_o, .last_o
  );

  logic [31:0] curve_tmax;
  logic [3:0]  curve_npts;
  logic [3:0]  curve_dims;
  logic [31:0] ctrl_pts [MaxPoints*MaxDims];

  sample_t     pending_samples[$];
  row_t        directed_rows[$];
  int          mismatches;
  int          n_writes;
  int          n_evals;
  int          n_samples;
  int          burst_left;
  logic        row_chk;
  logic [31:0] row_pos, row_vel, row_acc;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint lerp_step(longint p, longint q, logic [63:0] u);
    longint      d;
    logic [63:0] mag, r;
    d = q - p;
    mag = (d < 0) ? -d : d;
    r = (mag * u + 64'd536870912) >> 30;
    return (d < 0) ? p - longint'(r) : p + longint'(r);
  endfunction

  function automatic logic [63:0] scale_q16(logic [63:0] mag, logic [63:0] tm);
    return ((mag << 16) + tm / 2) / tm;
  endfunction

  function automatic logic [31:0] sat32(logic neg, logic [63:0] mag);
    if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return 32'(64'd0 - mag);
  endfunction

  task automatic evaluate_curve(logic [31:0] ts_in);
    logic [63:0] tm, ts, tc, u, n, vmag, amag, x;
    logic        past;
    int          np, nd, base;
    longint      buf_v[MaxPoints];
    longint      d1, d2;
    sample_t     s;
    tm = (curve_tmax == 0) ? 64'd1 : 64'(curve_tmax);
    ts = 64'(ts_in);
    past = ts > tm;
    tc = past ? tm : ts;
    u = ((tc << 30) + tm / 2) / tm;
    np = curve_npts;
    if (np < 3) np = 3;
    if (np > MaxPoints) np = MaxPoints;
    nd = curve_dims;
    if (nd < 1) nd = 1;
    if (nd > MaxDims) nd = MaxDims;
    n = np - 1;
    base = pending_samples.size();
    for (int d = 0; d < nd; d++) begin
      d1 = 0;
      d2 = 0;
      for (int k = 0; k < np; k++) buf_v[k] = longint'(signed'(ctrl_pts[k*MaxDims+d]));
      for (int cnt = np; cnt > 1; cnt--) begin
        if (cnt == 3) d2 = buf_v[2] - 2 * buf_v[1] + buf_v[0];
        if (cnt == 2) d1 = buf_v[1] - buf_v[0];
        for (int k = 0; k + 1 < cnt; k++) buf_v[k] = lerp_step(buf_v[k], buf_v[k+1], u);
      end
      vmag = ((d1 < 0) ? -d1 : d1) * n;
      s.vel = sat32(d1 < 0, scale_q16(vmag, tm));
      s.acc = '0;
      if (!past) begin
        amag = ((d2 < 0) ? -d2 : d2) * n * (n - 1);
        x = scale_q16(amag, tm);
        if (x > (64'd1 << 47)) x = 64'd1 << 47;
        s.acc = sat32(d2 < 0, scale_q16(x, tm));
      end
      s.coord = 3'(d);
      s.pos = buf_v[0][31:0];
      s.last = (d + 1 == nd);
      pending_samples.push_back(s);
    end
    if (row_chk) begin
      pending_samples[base].pos = row_pos;
      pending_samples[base].vel = row_vel;
      pending_samples[base].acc = row_acc;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (req_type_i == bte_pkg::REQ_WRITE) begin
        ctrl_pts[point_index_i*MaxDims+coord_index_i] <= coord_value_i;
        n_writes++;
      end else begin
        evaluate_curve(sample_time_i);
        n_evals++;
      end
    end
  end

  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_samples++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result coord %0d", out_coord_o);
      end else begin
        e = pending_samples.pop_front();
        if (out_coord_o !== e.coord || position_o !== e.pos || velocity_o !== e.vel ||
            acceleration_o !== e.acc || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp c%0d p%h v%h a%h l%0d got c%0d p%h v%h a%h l%0d",
                     e.coord, e.pos, e.vel, e.acc, e.last, out_coord_o, position_o,
                     velocity_o, acceleration_o, last_o);
        end
      end
    end
  end

  // receiver stall: switch at random between four patterns (none, 40% random, periodic, 85% random)
  int stall_cyc;
  int stall_mode;
  always @(negedge clk_i) begin
    stall_cyc++;
    if (stall_cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 40);
      2: out_stall_i <= (stall_cyc % 7) < 4;
      default: out_stall_i <= ($urandom_range(0, 99) < 85);
    endcase
  end

  task automatic send_item(logic req, logic [2:0] pi, logic [2:0] ci,
                           logic [31:0] val, logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    point_index_i <= pi;
    coord_index_i <= ci;
    coord_value_i <= val;
    sample_time_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bte_pkg::CFG_T_MAX:      curve_tmax = data;
      bte_pkg::CFG_NUM_POINTS: curve_npts = data[3:0];
      bte_pkg::CFG_DIMS:       curve_dims = data[3:0];
      default: ;
    endcase
  endtask

  task automatic add_row(logic req, logic [2:0] pi, logic [2:0] ci, logic [31:0] val,
                         logic [31:0] t, logic chk, logic [31:0] ep, logic [31:0] ev,
                         logic [31:0] ea);
    row_t r;
    r = '{req, pi, ci, val, t, chk, ep, ev, ea};
    directed_rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] tm;
    tm = (curve_tmax == 0) ? 32'd1 : curve_tmax;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return tm;
      2: return (tm == 32'hFFFF_FFFF) ? tm : tm + 32'd1;
      3: return 32'd0;
      default: return $urandom_range(0, tm);
    endcase
  endfunction

  initial begin
    logic [31:0] cfg_set [6][3];
    row_t r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = bte_pkg::REQ_WRITE;
    point_index_i = '0;
    coord_index_i = '0;
    coord_value_i = '0;
    sample_time_i = '0;
    out_stall_i = 1'b0;
    row_chk = 1'b0;
    burst_left = 0;
    curve_tmax = 32'd65536;
    curve_npts = 4'd4;
    curve_dims = 4'd3;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the whole table so no evaluation reads an unwritten entry
    for (int p = 0; p < MaxPoints; p++)
      for (int c = 0; c < MaxDims; c++)
        send_item(bte_pkg::REQ_WRITE, 3'(p), 3'(c), $urandom, $urandom);

    add_row(bte_pkg::REQ_WRITE, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd1, 3'd0, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd2, 3'd0, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd3, 3'd0, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_EVAL, 3'd0, 3'd0, 32'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_EVAL, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            32'h7FFF_FFFF, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_EVAL, 3'd0, 3'd0, 32'd0, 32'h0001_0000, 1'b1,
            32'h7FFF_FFFF, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd0, 3'd0, 32'h8000_0000, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd2, 3'd0, 32'h8000_0000, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_EVAL, 3'd0, 3'd0, 32'd0, 32'h0, 1'b1,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_row(bte_pkg::REQ_EVAL, 3'd0, 3'd0, 32'd0, 32'h0000_8000, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_EVAL, 3'd0, 3'd0, 32'd0, 32'h0001_0001, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd7, 3'd7, 32'h8000_0000, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd7, 3'd7, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_WRITE, 3'd3, 3'd2, 32'h0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    add_row(bte_pkg::REQ_EVAL, 3'd0, 3'd0, 32'd0, 32'h0000_4000, 1'b0, 32'd0, 32'd0, 32'd0);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      row_chk = r.chk;
      row_pos = r.epos;
      row_vel = r.evel;
      row_acc = r.eacc;
      send_item(r.req, r.pi, r.ci, r.val, r.t);
      row_chk = 1'b0;
    end

    cfg_set[0] = '{32'd1, 32'd3, 32'd1};
    cfg_set[1] = '{32'hFFFF_FFFF, 32'd8, 32'd8};
    cfg_set[2] = '{32'd0, 32'd15, 32'd0};
    cfg_set[3] = '{32'd0, 32'd2, 32'd15};
    cfg_set[4] = '{32'h0003_0000, 32'd5, 32'd2};
    cfg_set[5] = '{$urandom, 32'($urandom_range(0, 15)), 32'($urandom_range(0, 15))};
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_cfg(bte_pkg::CFG_T_MAX, cfg_set[ph][0]);
      write_cfg(bte_pkg::CFG_NUM_POINTS, cfg_set[ph][1]);
      write_cfg(bte_pkg::CFG_DIMS, cfg_set[ph][2]);
      write_cfg(bte_pkg::CFG_UNUSED, $urandom);
      for (int i = 0; i < 22; i++) begin
        if (i == 11) wait_idle();
        if ($urandom_range(0, 99) < 45)
          send_item(bte_pkg::REQ_EVAL, 3'($urandom), 3'($urandom), $urandom, pick_time());
        else
          send_item(bte_pkg::REQ_WRITE, 3'($urandom), 3'($urandom), $urandom, $urandom);
      end
    end

    wait_idle();
    repeat (200) @(negedge clk_i);
    $display("covered %0d point writes and %0d evaluations, %0d coordinate results",
             n_writes, n_evals, n_samples);
    $display("six register settings including t_max of 0, 1 and full scale");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
